[design/jer_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Jet energy resolution package
// Field widths, fixed-point formats and the per-bin tables, all built at
// elaboration from the decimal coefficients and the eta bin edges.
// ----------------------------------------------------------------------------
package jer_pkg;

   // Fixed-point grids of the ports
   localparam int ETA_FRAC_BITS = 12;
   localparam int ET_FRAC_BITS  = 8;

   localparam int ETA_W    = 16;
   localparam int ET_W     = 20;
   localparam int RES_W    = 20;
   localparam int NUM_BINS = 26;
   localparam int BIN_W    = $clog2(NUM_BINS);

   // |eta| edges: 2.5 < 2^2, so two integer bits
   localparam int EDGE_W = ETA_FRAC_BITS + 2;
   localparam int CMP_W  = (ETA_W > EDGE_W) ? ETA_W : EDGE_W;

   // Coefficient formats
   localparam int C_Q     = 24;
   localparam int N_Q     = 20;
   localparam int S_Q     = 24;
   localparam int C_W     = 21;
   localparam int N_W     = 21;
   localparam int S_W     = 26;
   localparam int NN_W    = 2 * N_W;
   localparam int NN_LO_W = N_W;
   localparam int NN_HI_W = NN_W - NN_LO_W;
   localparam int SS_W    = 2 * S_W;

   // Constant term: p = round(c * et / 2^20), squared
   localparam int CM_W  = C_W + ET_W;
   localparam int P_SH  = 20;
   localparam int P_RND = 1 << (P_SH - 1);
   localparam int P_W   = CM_W + 1 - P_SH;
   localparam int TC_W  = 2 * P_W;

   // Noise term: n*n*et split into two partial products
   localparam int MH_W  = NN_HI_W + ET_W;
   localparam int ML_W  = NN_LO_W + ET_W;
   localparam int NNE_W = NN_W + ET_W;
   localparam int TN_SH = 32 - ET_FRAC_BITS;
   localparam int TN_W  = NNE_W - TN_SH;

   // Stochastic term, a per-bin constant
   localparam int TS_SH = 40 - 2 * ET_FRAC_BITS;
   localparam int TS_W  = SS_W - TS_SH + 1;

   localparam int NT_W      = ((TN_W > TS_W) ? TN_W : TS_W) + 1;
   localparam int SUM_RAW_W = ((TC_W > NT_W) ? TC_W : NT_W) + 1;
   localparam int SUM_W     = SUM_RAW_W + (SUM_RAW_W % 2);
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 2;

   // Final scaling by cosh(bin midpoint), Q16
   localparam int COSH_W  = 20;
   localparam int PROD_W  = ROOT_W + COSH_W;
   localparam int RES_SH  = 20;
   localparam int RES_RND = 1 << (RES_SH - 1);
   localparam int SCL_W   = PROD_W + 1 - RES_SH;

   localparam logic [RES_W-1:0] RES_MAX     = '1;
   localparam logic [RES_W-1:0] RES_OUTSIDE = RES_W'(10 << ET_FRAC_BITS);

   // Bin edges in thousandths of a unit of eta
   localparam int EDGE_MILLI [NUM_BINS+1] = '{
      0, 87, 174, 261, 348, 435, 522, 609, 696, 783, 870, 957, 1044, 1131,
      1218, 1305, 1392, 1479, 1566, 1653, 1740, 1830, 1930, 2043, 2172, 2322, 2500
   };

   // Coefficients as mantissa * 10^-exponent
   localparam int C_MAN [NUM_BINS] = '{
      686, 737, 657, 62, 605, 59, 577, 525, 582, 649, 654, 669, 643,
      645, 637, 695, 748, 624, 283, 316, 229, 518, 217, 365, 202, 527
   };
   localparam int C_EXP [NUM_BINS] = '{
      4, 4, 4, 3, 4, 3, 4, 4, 4, 4, 4, 4, 4,
      4, 4, 4, 4, 4, 4, 4, 9, 11, 9, 9, 9, 9
   };
   localparam int N_MAN [NUM_BINS] = '{
      103, 101, 107, 107, 107, 108, 108, 109, 109, 108, 11, 111, 115,
      116, 119, 121, 12, 123, 125, 121, 12, 114, 109, 109, 109, 112
   };
   localparam int N_EXP [NUM_BINS] = '{
      2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 1, 2, 2,
      2, 2, 2, 1, 2, 2, 2, 1, 2, 2, 2, 2, 2
   };
   localparam int S_MAN [NUM_BINS] = '{
      168, 174, 516, 134, 184, 906, 546, 405, 117, 785, 109, 187, 276,
      104, 108, 575, 515, 228, 479, 5, 171, 17, 208, 163, 168, 178
   };
   localparam int S_EXP [NUM_BINS] = '{
      2, 2, 8, 6, 9, 11, 8, 7, 7, 8, 9, 8, 7,
      8, 9, 8, 10, 7, 9, 5, 7, 1, 2, 2, 2, 2
   };

   typedef struct packed {
      logic             valid;
      logic             in_acc;
      logic [BIN_W-1:0] bin;
   } tag_type;

   typedef struct packed {
      logic [C_W-1:0]  c;
      logic [NN_W-1:0] nn;
      logic [TS_W-1:0] ts;
   } coef_type;

   typedef struct packed {
      logic [RES_W-1:0] energy;
      logic             in_acc;
   } res_type;

   typedef coef_type [NUM_BINS-1:0]               coef_tab_type;
   typedef logic     [NUM_BINS:0][EDGE_W-1:0]     edge_tab_type;
   typedef logic     [NUM_BINS-1:0][COSH_W-1:0]   cosh_tab_type;

   // quotient by shift and subtract, for the table builders
   function automatic longint unsigned div_u64(longint unsigned num,
                                               longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = (r << 1) | ((num >> i) & 64'd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'd1 << i);
         end
      end
      return q;
   endfunction

   function automatic longint unsigned pow_ten(int k);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < k; i++) p = p * 10;
      return p;
   endfunction

   // round(m * 10^-k * 2^q), half up
   function automatic longint unsigned dec_fixed(int m, int k, int q);
      longint unsigned p;
      longint unsigned mm;
      p  = pow_ten(k);
      mm = longint'(m);
      return div_u64((mm << q) + (p >> 1), p);
   endfunction

   // cosh(sum_milli / 2000) as a Taylor series in Q28, rounded to Q16
   function automatic longint unsigned cosh_q16(int sum_milli);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned sm;
      longint unsigned j;
      sm   = longint'(sum_milli);
      x    = div_u64((sm << 28) + 1000, 2000);
      x2   = (x * x + (64'd1 << 27)) >> 28;
      term = 64'd1 << 28;
      acc  = term;
      for (j = 1; j <= 15; j++) begin
         term = div_u64((term * x2) >> 28, (2 * j - 1) * (2 * j));
         acc  = acc + term;
      end
      return (acc + 2048) >> 12;
   endfunction

   function automatic edge_tab_type build_edges();
      edge_tab_type    t;
      longint unsigned v;
      for (int i = 0; i <= NUM_BINS; i++) begin
         v    = longint'(EDGE_MILLI[i]);
         t[i] = EDGE_W'(div_u64((v << ETA_FRAC_BITS) + 500, 1000));
      end
      return t;
   endfunction

   function automatic coef_tab_type build_coefs();
      coef_tab_type    t;
      longint unsigned c;
      longint unsigned n;
      longint unsigned s;
      for (int i = 0; i < NUM_BINS; i++) begin
         c       = dec_fixed(C_MAN[i], C_EXP[i], C_Q);
         n       = dec_fixed(N_MAN[i], N_EXP[i], N_Q);
         s       = dec_fixed(S_MAN[i], S_EXP[i], S_Q);
         t[i].c  = C_W'(c);
         t[i].nn = NN_W'(n * n);
         t[i].ts = TS_W'((s * s + (64'd1 << (TS_SH - 1))) >> TS_SH);
      end
      return t;
   endfunction

   function automatic cosh_tab_type build_cosh();
      cosh_tab_type t;
      for (int i = 0; i < NUM_BINS; i++) begin
         t[i] = COSH_W'(cosh_q16(EDGE_MILLI[i] + EDGE_MILLI[i+1]));
      end
      return t;
   endfunction

   localparam edge_tab_type EDGE_TAB = build_edges();
   localparam coef_tab_type COEF_TAB = build_coefs();
   localparam cosh_tab_type COSH_TAB = build_cosh();

endpackage
`default_nettype wire

[design/jer_bin_lookup.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Eta bin lookup
// Three stages: |eta| against edges 1..26, bin encode, coefficient table read.
// ----------------------------------------------------------------------------
module jer_bin_lookup import jer_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    valid_i,
   input  logic signed [ETA_W-1:0] eta_i,
   input  logic [ET_W-1:0]         et_i,
   output tag_type                 tag_o,
   output logic [ET_W-1:0]         et_o,
   output coef_type                coef_o
);

   logic [ETA_W-1:0]    eta_u;
   logic [ETA_W-1:0]    aeta;
   logic [NUM_BINS:1]   thermo_in;
   logic [NUM_BINS:1]   thermo_ff;
   logic                valid1_ff;
   logic [ET_W-1:0]     et1_ff;

   tag_type             tag2_in;
   tag_type             tag2_ff;
   logic [ET_W-1:0]     et2_ff;

   tag_type             tag3_ff;
   logic [ET_W-1:0]     et3_ff;
   coef_type            coef3_ff;

   // stage 1: magnitude and edge compares
   always_comb begin
      eta_u = eta_i;
      aeta  = eta_u[ETA_W-1] ? (~eta_u + 1'b1) : eta_u;
      for (int i = 1; i <= NUM_BINS; i++) begin
         thermo_in[i] = CMP_W'(aeta) >= CMP_W'(EDGE_TAB[i]);
      end
   end

   // stage 2: edges are increasing, so the highest passed edge is the bin
   always_comb begin
      tag2_in.valid  = valid1_ff;
      tag2_in.in_acc = !thermo_ff[NUM_BINS];
      tag2_in.bin    = '0;
      for (int i = 1; i < NUM_BINS; i++) begin
         if (thermo_ff[i]) tag2_in.bin = BIN_W'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         tag2_ff   <= '0;
         tag3_ff   <= '0;
      end else if (adv) begin
         valid1_ff <= valid_i;
         tag2_ff   <= tag2_in;
         tag3_ff   <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         thermo_ff <= thermo_in;
         et1_ff    <= et_i;
         et2_ff    <= et1_ff;
         et3_ff    <= et2_ff;
         coef3_ff  <= COEF_TAB[tag2_ff.bin];
      end
   end

   assign tag_o  = tag3_ff;
   assign et_o   = et3_ff;
   assign coef_o = coef3_ff;

endmodule
`default_nettype wire

[design/jer_quad_sum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Quadrature sum
// c^2*et^2 + n^2*et + s^2 in four stages: products, rounding, square, add.
// ----------------------------------------------------------------------------
module jer_quad_sum import jer_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  tag_type           tag_i,
   input  logic [ET_W-1:0]   et_i,
   input  coef_type          coef_i,
   output tag_type           tag_o,
   output logic [SUM_W-1:0]  sum_o
);

   tag_type            tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   logic [CM_W-1:0]    cm_in, cm_ff;
   logic [MH_W-1:0]    mh_in, mh_ff;
   logic [ML_W-1:0]    ml_in, ml_ff;
   logic [TS_W-1:0]    ts1_ff, ts2_ff;

   logic [CM_W:0]      cm_rnd;
   logic [NNE_W-1:0]   nne;
   logic [P_W-1:0]     p_ff;
   logic [TN_W-1:0]    tn_ff;

   logic [TC_W-1:0]    tc_in, tc_ff;
   logic [NT_W-1:0]    nt_in, nt_ff;

   logic [SUM_W-1:0]   sum_in, sum_ff;

   always_comb begin
      // stage 1: c*et, and n*n*et as high and low partial products
      cm_in = CM_W'(coef_i.c) * CM_W'(et_i);
      mh_in = MH_W'(coef_i.nn[NN_W-1 -: NN_HI_W]) * MH_W'(et_i);
      ml_in = ML_W'(coef_i.nn[NN_LO_W-1:0]) * ML_W'(et_i);

      // stage 2: round both
      cm_rnd = {1'b0, cm_ff} + (CM_W+1)'(P_RND);
      nne    = {mh_ff, {NN_LO_W{1'b0}}} + NNE_W'(ml_ff) + (NNE_W'(1) << (TN_SH - 1));

      // stage 3 and 4
      tc_in  = TC_W'(p_ff) * TC_W'(p_ff);
      nt_in  = NT_W'(tn_ff) + NT_W'(ts2_ff);
      sum_in = SUM_W'(tc_ff) + SUM_W'(nt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else if (adv) begin
         tag1_ff <= tag_i;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cm_ff  <= cm_in;
         mh_ff  <= mh_in;
         ml_ff  <= ml_in;
         ts1_ff <= coef_i.ts;
         p_ff   <= cm_rnd[CM_W -: P_W];
         tn_ff  <= nne[NNE_W-1 -: TN_W];
         ts2_ff <= ts1_ff;
         tc_ff  <= tc_in;
         nt_ff  <= nt_in;
         sum_ff <= sum_in;
      end
   end

   assign tag_o = tag4_ff;
   assign sum_o = sum_ff;

endmodule
`default_nettype wire

[design/jer_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, restoring digit recurrence.
// ----------------------------------------------------------------------------
module jer_isqrt import jer_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  tag_type            tag_i,
   input  logic [SUM_W-1:0]   rad_i,
   output tag_type            tag_o,
   output logic [ROOT_W-1:0]  root_o
);

   logic [REM_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];
   logic [SUM_W-1:0]   rad_ff  [ROOT_W];
   tag_type            tag_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]   rem_prev;
      logic [ROOT_W-1:0]  root_prev;
      logic [SUM_W-1:0]   rad_prev;
      tag_type            tag_prev;
      logic [REM_W-1:0]   rem_sh;
      logic [REM_W-1:0]   trial;
      logic [REM_W-1:0]   rem_in;
      logic [ROOT_W-1:0]  root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_i;
         assign tag_prev  = tag_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign tag_prev  = tag_ff[k-1];
      end

      // remainder is at most 2*root, so its top two bits are free
      always_comb begin
         rem_sh = {rem_prev[REM_W-3:0], rad_prev[SUM_W-1 -: 2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (adv) begin
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_prev[SUM_W-3:0], 2'b00};
         end
      end
   end

   assign tag_o  = tag_ff[ROOT_W-1];
   assign root_o = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

[design/jer_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Resolution scaling
// Multiplies the root by the bin's cosh factor, rounds, saturates, and
// substitutes the fixed value outside the acceptance.
// ----------------------------------------------------------------------------
module jer_scale import jer_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  tag_type            tag_i,
   input  logic [ROOT_W-1:0]  root_i,
   output logic               valid_o,
   output res_type            res_o
);

   tag_type             tag1_ff, tag2_ff;
   logic [ROOT_W-1:0]   root1_ff;
   logic [COSH_W-1:0]   cosh1_ff;
   logic [PROD_W-1:0]   prod_in, prod_ff;
   logic [PROD_W:0]     prod_rnd;
   logic [SCL_W-1:0]    scaled;
   res_type             res_in, res_ff;
   logic                valid3_ff;

   always_comb begin
      prod_in  = PROD_W'(root1_ff) * PROD_W'(cosh1_ff);
      prod_rnd = {1'b0, prod_ff} + (PROD_W+1)'(RES_RND);
      scaled   = prod_rnd[PROD_W -: SCL_W];

      res_in.in_acc = tag2_ff.in_acc;
      if (!tag2_ff.in_acc) begin
         res_in.energy = RES_OUTSIDE;
      end else if (scaled > SCL_W'(RES_MAX)) begin
         res_in.energy = RES_MAX;
      end else begin
         res_in.energy = scaled[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff   <= '0;
         tag2_ff   <= '0;
         valid3_ff <= 1'b0;
      end else if (adv) begin
         tag1_ff   <= tag_i;
         tag2_ff   <= tag1_ff;
         valid3_ff <= tag2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root1_ff <= root_i;
         cosh1_ff <= COSH_TAB[tag_i.bin];
         prod_ff  <= prod_in;
         res_ff   <= res_in;
      end
   end

   assign valid_o = valid3_ff;
   assign res_o   = res_ff;

endmodule
`default_nettype wire

[design/jet_energy_resolution_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Jet energy resolution core
// Per jet, cosh(bin midpoint) * sqrt(c^2*et^2 + n^2*et + s^2) from an
// absolute-eta bin table; fixed 10 GeV outside |eta| < 2.5.
// ----------------------------------------------------------------------------
// Structure: an accepted req item passes 3 lookup, 4 sum, 23 root, 3 scale
//   stages and 1 buffer register; the square root is the longest part.
// Throughput: one item per clock; the pipeline holds while the 2-entry
//   output buffer is full.
// Reset: clears all stage valid bits and empties the output buffer.
// ----------------------------------------------------------------------------
module jet_energy_resolution_core import jer_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [ETA_W-1:0] req_pseudorapidity,
   input  logic [ET_W-1:0]         req_transverse_energy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RES_W-1:0]        rsp_energy_resolution,
   output logic                    rsp_in_acceptance
);

   localparam logic [1:0] SLOTS = 2'd2;

   logic               adv;
   tag_type            lk_tag, qs_tag, sq_tag;
   logic [ET_W-1:0]    lk_et;
   coef_type           lk_coef;
   logic [SUM_W-1:0]   qs_sum;
   logic [ROOT_W-1:0]  sq_root;
   logic               pipe_valid;
   res_type            pipe_res;

   res_type            slot_ff [2];
   logic [1:0]         count_ff;
   logic               push;
   logic               pop;

   jer_bin_lookup u_lookup (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid_i (req_valid),
      .eta_i   (req_pseudorapidity),
      .et_i    (req_transverse_energy),
      .tag_o   (lk_tag),
      .et_o    (lk_et),
      .coef_o  (lk_coef)
   );

   jer_quad_sum u_quad (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .tag_i  (lk_tag),
      .et_i   (lk_et),
      .coef_i (lk_coef),
      .tag_o  (qs_tag),
      .sum_o  (qs_sum)
   );

   jer_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .tag_i  (qs_tag),
      .rad_i  (qs_sum),
      .tag_o  (sq_tag),
      .root_o (sq_root)
   );

   jer_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .tag_i   (sq_tag),
      .root_i  (sq_root),
      .valid_o (pipe_valid),
      .res_o   (pipe_res)
   );

   // the whole pipeline moves unless both buffer slots are taken
   assign adv       = (count_ff != SLOTS);
   assign req_ready = adv;
   assign push      = pipe_valid && adv;
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            2'b00,
            2'b11:   count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push && (count_ff == '0 || pop)) begin
         slot_ff[0] <= pipe_res;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
      end
      if (push && !pop && count_ff == 2'd1) begin
         slot_ff[1] <= pipe_res;
      end
   end

   assign rsp_valid             = (count_ff != '0);
   assign rsp_energy_resolution = slot_ff[0].energy;
   assign rsp_in_acceptance     = slot_ff[0].in_acc;

endmodule
`default_nettype wire

[dv/jet_energy_resolution_core_tb.sv]
// ----------------------------------------------------------------------------
// Jet energy resolution core testbench
// Offers jets on the req channel and takes results on the rsp channel, with
// random idle bursts on both sides, one long receiver hold-off that backs the
// pipeline up, and one sender pause that drains it. A directed list covers
// the eta and Et extremes, the bin edges, zero energy and the outside-
// acceptance default; random jets follow. Every result is checked, in order,
// against an in-bench fixed-point model or a listed expected value.
// ----------------------------------------------------------------------------
module jet_energy_resolution_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ETA_W    = jer_pkg::ETA_W;
   localparam int ET_W     = jer_pkg::ET_W;
   localparam int RES_W    = jer_pkg::RES_W;
   localparam int ETA_FRAC = jer_pkg::ETA_FRAC_BITS;
   localparam int ET_FRAC  = jer_pkg::ET_FRAC_BITS;

   localparam int JET_BINS     = 26;
   localparam int TOTAL_JETS   = 750;
   localparam int QUIET_JETS   = 100;
   localparam int LONG_HOLD_AT = 200;
   localparam int LONG_HOLD    = 120;
   localparam int DRAIN_AT     = 400;
   localparam int SETTLE       = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;

   localparam logic [RES_W-1:0] OUTSIDE_RES = RES_W'(10 << ET_FRAC);
   localparam logic [RES_W-1:0] RES_CEIL    = '1;
   localparam logic [ET_W-1:0]  ET_TOP      = '1;

   typedef logic [63:0] u64;

   typedef struct {
      logic [RES_W-1:0] energy;
      logic             accepted;
   } jer_result_t;

   typedef struct {
      logic [ETA_W-1:0] eta;
      logic [ET_W-1:0]  et;
      bit               known;
      logic [RES_W-1:0] res;
      logic             acc;
   } jet_row_t;

   // bin boundaries in thousandths of eta; coefficients as mantissa * 10^-exp
   localparam int BOUND_MILLI [JET_BINS+1] = '{
      0, 87, 174, 261, 348, 435, 522, 609, 696, 783, 870, 957, 1044, 1131,
      1218, 1305, 1392, 1479, 1566, 1653, 1740, 1830, 1930, 2043, 2172, 2322, 2500
   };
   localparam int CONST_M [JET_BINS] = '{
      686, 737, 657, 62, 605, 59, 577, 525, 582, 649, 654, 669, 643,
      645, 637, 695, 748, 624, 283, 316, 229, 518, 217, 365, 202, 527
   };
   localparam int CONST_X [JET_BINS] = '{
      4, 4, 4, 3, 4, 3, 4, 4, 4, 4, 4, 4, 4,
      4, 4, 4, 4, 4, 4, 4, 9, 11, 9, 9, 9, 9
   };
   localparam int NOISE_M [JET_BINS] = '{
      103, 101, 107, 107, 107, 108, 108, 109, 109, 108, 11, 111, 115,
      116, 119, 121, 12, 123, 125, 121, 12, 114, 109, 109, 109, 112
   };
   localparam int NOISE_X [JET_BINS] = '{
      2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 1, 2, 2,
      2, 2, 2, 1, 2, 2, 2, 1, 2, 2, 2, 2, 2
   };
   localparam int STOCH_M [JET_BINS] = '{
      168, 174, 516, 134, 184, 906, 546, 405, 117, 785, 109, 187, 276,
      104, 108, 575, 515, 228, 479, 5, 171, 17, 208, 163, 168, 178
   };
   localparam int STOCH_X [JET_BINS] = '{
      2, 2, 8, 6, 9, 11, 8, 7, 7, 8, 9, 8, 7,
      8, 9, 8, 10, 7, 9, 5, 7, 1, 2, 2, 2, 2
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [ETA_W-1:0] req_pseudorapidity = '0;
   logic [ET_W-1:0]  req_transverse_energy = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [RES_W-1:0] rsp_energy_resolution;
   logic             rsp_in_acceptance;

   jer_result_t pending_resolutions[$];
   int          jets_sent = 0;
   int          results_seen = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;
   bit          long_hold_done = 1'b0;
   jet_row_t    directed_jets [20];

   jet_energy_resolution_core uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_pseudorapidity    (req_pseudorapidity),
      .req_transverse_energy (req_transverse_energy),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_energy_resolution (rsp_energy_resolution),
      .rsp_in_acceptance     (rsp_in_acceptance)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic u64 bound_code(int i);
      return ((u64'(BOUND_MILLI[i]) << ETA_FRAC) + 64'd500) / 64'd1000;
   endfunction

   // round(m * 10^-x * 2^q), half up
   function automatic u64 decimal_to_q(int m, int x, int q);
      u64 scale;
      scale = 64'd1;
      for (int i = 0; i < x; i++) scale = scale * 64'd10;
      return ((u64'(m) << q) + scale / 2) / scale;
   endfunction

   // cosh(sum_milli / 2000), Taylor series in Q28, rounded to Q16
   function automatic u64 cosh_mid_q16(int sum_milli);
      u64 x;
      u64 x_sq;
      u64 term;
      u64 total;
      x     = ((u64'(sum_milli) << 28) + 64'd1000) / 64'd2000;
      x_sq  = (x * x + (64'd1 << 27)) >> 28;
      term  = 64'd1 << 28;
      total = term;
      for (int j = 1; j <= 15; j++) begin
         term  = ((term * x_sq) >> 28) / u64'((2 * j - 1) * (2 * j));
         total = total + term;
      end
      return (total + 64'd2048) >> 12;
   endfunction

   function automatic u64 floor_sqrt(u64 v);
      u64 root;
      u64 b;
      root = '0;
      b    = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v    = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic jer_result_t predict_jer(logic [ETA_W-1:0] eta, logic [ET_W-1:0] et);
      jer_result_t r;
      u64          abs_eta;
      u64          e;
      u64          c;
      u64          n;
      u64          s;
      u64          p;
      u64          sum;
      u64          scaled;
      int          bin;
      e       = u64'(et);
      abs_eta = eta[ETA_W-1] ? (64'd1 << ETA_W) - u64'(eta) : u64'(eta);
      if (abs_eta >= bound_code(JET_BINS)) begin
         r.energy   = OUTSIDE_RES;
         r.accepted = 1'b0;
         return r;
      end
      bin = 0;
      for (int i = 1; i < JET_BINS; i++)
         if (abs_eta >= bound_code(i)) bin = i;
      c = decimal_to_q(CONST_M[bin], CONST_X[bin], 24);
      n = decimal_to_q(NOISE_M[bin], NOISE_X[bin], 20);
      s = decimal_to_q(STOCH_M[bin], STOCH_X[bin], 24);
      p   = (c * e + (64'd1 << 19)) >> 20;
      sum = p * p;
      sum = sum + ((n * n * e + (64'd1 << (31 - ET_FRAC))) >> (32 - ET_FRAC));
      sum = sum + ((s * s + (64'd1 << (39 - 2 * ET_FRAC))) >> (40 - 2 * ET_FRAC));
      scaled = (floor_sqrt(sum) * cosh_mid_q16(BOUND_MILLI[bin] + BOUND_MILLI[bin+1])
                + (64'd1 << 19)) >> 20;
      r.energy   = (scaled > u64'(RES_CEIL)) ? RES_CEIL : RES_W'(scaled);
      r.accepted = 1'b1;
      return r;
   endfunction

   // ---------------------------------------------------------------- sender

   function automatic bit gaps_enabled();
      return (jets_sent < TOTAL_JETS - QUIET_JETS) && ((jets_sent / 64) % 3 != 2);
   endfunction

   task automatic sender_gap();
      if (gaps_enabled() && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic offer_jet(input logic [ETA_W-1:0] eta, input logic [ET_W-1:0] et,
                            input bit known, input jer_result_t typed);
      req_valid             <= 1'b1;
      req_pseudorapidity    <= eta;
      req_transverse_energy <= et;
      do @(posedge clock); while (!req_ready);
      pending_resolutions.push_back(known ? typed : predict_jer(eta, et));
      jets_sent++;
   endtask

   function automatic logic [ETA_W-1:0] random_eta();
      int v;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         v = int'($urandom_range(0, 20478)) - 10239;
      end else if (pick < 85) begin
         v = int'($urandom_range(0, 65535));
      end else begin
         // straddle a bin boundary, either sign
         v = int'(bound_code($urandom_range(0, JET_BINS))) + int'($urandom_range(0, 4)) - 2;
         if (v < 0) v = 0;
         if ($urandom_range(0, 1) == 1) v = -v;
      end
      return ETA_W'(v);
   endfunction

   function automatic logic [ET_W-1:0] random_et();
      int w;
      w = $urandom_range(0, ET_W);
      if ($urandom_range(0, 19) == 0) return ET_TOP;
      return ET_W'($urandom) & ET_W'((64'd1 << w) - 1);
   endfunction

   initial begin
      jer_result_t typed;
      directed_jets = '{
         '{ETA_W'(0),      ET_W'(0),        1'b0, '0, 1'b0},  // zero energy, central
         '{ETA_W'(0),      ET_TOP,          1'b0, '0, 1'b0},
         '{ETA_W'(1),      ET_W'(1),        1'b0, '0, 1'b0},
         '{ETA_W'(-1),     ET_W'(256),      1'b0, '0, 1'b0},
         '{ETA_W'(355),    ET_W'(25600),    1'b0, '0, 1'b0},  // just below first boundary
         '{ETA_W'(356),    ET_W'(25600),    1'b0, '0, 1'b0},
         '{ETA_W'(-356),   ET_W'(25600),    1'b0, '0, 1'b0},
         '{ETA_W'(10239),  ET_TOP,          1'b0, '0, 1'b0},  // last bin, edge of acceptance
         '{ETA_W'(-10239), ET_W'(0),        1'b0, '0, 1'b0},
         '{ETA_W'(10240),  ET_W'(1234),     1'b1, OUTSIDE_RES, 1'b0},
         '{ETA_W'(-10240), ET_TOP,          1'b1, OUTSIDE_RES, 1'b0},
         '{ETA_W'(32767),  ET_W'(0),        1'b1, OUTSIDE_RES, 1'b0},
         '{ETA_W'(-32768), ET_TOP,          1'b1, OUTSIDE_RES, 1'b0},
         '{ETA_W'('h5555), ET_W'('hAAAAA),  1'b1, OUTSIDE_RES, 1'b0},
         '{ETA_W'('hAAAA), ET_W'('h55555),  1'b1, OUTSIDE_RES, 1'b0},
         '{ETA_W'(7300),   ET_W'(0),        1'b0, '0, 1'b0},  // bin 20, tiny stochastic term
         '{ETA_W'(7300),   ET_TOP,          1'b0, '0, 1'b0},
         '{ETA_W'(4000),   ET_W'('h80000),  1'b0, '0, 1'b0},
         '{ETA_W'(-9511),  ET_W'(5000),     1'b0, '0, 1'b0},
         '{ETA_W'(2000),   ET_W'('h7FFFF),  1'b0, '0, 1'b0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_jets[i]) begin
         typed.energy   = directed_jets[i].res;
         typed.accepted = directed_jets[i].acc;
         if (i > 0) sender_gap();
         offer_jet(directed_jets[i].eta, directed_jets[i].et, directed_jets[i].known, typed);
      end
      typed.energy   = '0;
      typed.accepted = 1'b0;
      while (jets_sent < TOTAL_JETS) begin
         if (jets_sent == DRAIN_AT) begin
            // let the pipeline run dry before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_resolutions.size() != 0) @(posedge clock);
         end else begin
            sender_gap();
         end
         offer_jet(random_eta(), random_et(), 1'b0, typed);
      end
      req_valid <= 1'b0;
      while (pending_resolutions.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && jets_sent >= LONG_HOLD_AT) begin
            // hold off long enough for the block to fill and stall req
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (gaps_enabled() && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string field, input u64 want, input u64 got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on item %0d, %s: expected 0x%0h, got 0x%0h",
                  results_seen, field, want, got);
   endtask

   always @(posedge clock) begin
      jer_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_resolutions.size() == 0) begin
            flag_mismatch("unexpected item", 0, u64'(rsp_energy_resolution));
         end else begin
            want = pending_resolutions.pop_front();
            if (rsp_energy_resolution !== want.energy)
               flag_mismatch("energy_resolution", u64'(want.energy),
                             u64'(rsp_energy_resolution));
            if (rsp_in_acceptance !== want.accepted)
               flag_mismatch("in_acceptance", u64'(want.accepted), u64'(rsp_in_acceptance));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

[files.f]
design/jer_pkg.sv
design/jer_bin_lookup.sv
design/jer_quad_sum.sv
design/jer_isqrt.sv
design/jer_scale.sv
design/jet_energy_resolution_core.sv
dv/jet_energy_resolution_core_tb.sv
